[design/mwpa_pkg.sv]
// Package for the masked window pixel access block: image geometry, field widths,
// register indexes and the access descriptor passed from cursor to datapath.
// No dependencies.
`default_nettype none

package mwpa_pkg;

  localparam int PLANE_COUNT  = 4;
  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;
  localparam int STORE_SIZE   = PLANE_COUNT * IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W       = $clog2(STORE_SIZE);

  localparam int PIXEL_W     = 8;
  localparam int COORD_W     = 8;
  localparam int PLANE_SEL_W = 2;
  localparam int REG_INDEX_W = 3;

  localparam logic [REG_INDEX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_WINDOW_TOP    = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_WINDOW_RIGHT  = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_WINDOW_BOTTOM = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_PLANE_SELECT  = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_BIT_MASK      = 3'd5;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
    logic               in_range;
  } access_t;

endpackage

`default_nettype wire

[design/mwpa_ifs.sv]
// Handshake interfaces of the masked window pixel access block: request,
// response and configuration channels. Depends on mwpa_pkg.
`default_nettype none

interface mwpa_req_if import mwpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [PIXEL_W-1:0] pixel_data;
  logic               last_item;

  modport source (output valid, req_type, pixel_data, last_item, input ready);
  modport sink   (input valid, req_type, pixel_data, last_item, output ready);
endinterface

interface mwpa_rsp_if import mwpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] read_data;
  logic [COORD_W-1:0] pixel_column;
  logic [COORD_W-1:0] pixel_line;

  modport source (output valid, read_data, pixel_column, pixel_line, input ready);
  modport sink   (input valid, read_data, pixel_column, pixel_line, output ready);
endinterface

interface mwpa_cfg_if import mwpa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [REG_INDEX_W-1:0] index;
  logic [PIXEL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/masked_window_pixel_access.sv]
// Top level of the masked window pixel access block: clearing pass, masked
// read-modify-write pipeline with forwarding, output register.
// Depends on mwpa_pkg, mwpa_ifs, mwpa_cursor, mwpa_image_ram.
//
// Usage:
//  - cfg: register writes (index, data), always ready. Writing any window
//    register sends the cursor back to the window origin.
//  - req: one word per pixel access (write or read) at the cursor, which
//    walks the window row-major, wraps past the bottom row, and returns to
//    the origin after a word marked last_item.
//  - rsp: one word per request: read data (zero on write or out-of-range read), column, line.
// Pipeline: an accepted request passes the read stage and then the output
//   register before its response is valid. Throughput is one word per cycle
//   while rsp.ready is high: the image memory does one read and one write per
//   cycle, and a same-address write directly ahead is forwarded.
// Reset: rst (synchronous) starts a clearing pass that zeroes all STORE_SIZE
//   entries (262144 as configured) of the image memory, one entry per cycle;
//   req.ready stays low meanwhile, cfg writes are still taken.
// Stall: with rsp stalled, one word waits in the output register and one in
//   the read stage; req.ready then drops until rsp.ready returns.
`default_nettype none

module masked_window_pixel_access import mwpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mwpa_cfg_if.sink  cfg,
  mwpa_req_if.sink  req,
  mwpa_rsp_if.source rsp
);

  // read stage descriptor
  typedef struct packed {
    access_t            acc;
    logic               is_read;
    logic [PIXEL_W-1:0] data;
  } stage_t;

  access_t            acc;
  logic [PIXEL_W-1:0] bit_mask;

  logic               req_fire;
  logic               s1_valid;
  stage_t             s1;
  logic               s1_adv;

  logic               clearing;
  logic [ADDR_W-1:0]  clr_addr;

  logic [PIXEL_W-1:0] ram_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;

  // last committed write, for the read-first collision
  logic               wr_valid;
  logic [ADDR_W-1:0]  wr_addr;
  logic [PIXEL_W-1:0] wr_data;

  logic [PIXEL_W-1:0] old_pixel;
  logic [PIXEL_W-1:0] merged;
  logic               commit;

  logic               out_valid;
  logic [PIXEL_W-1:0] out_data;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_line;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !clearing && (!s1_valid || s1_adv);
  assign req_fire  = req.valid && req.ready;

  mwpa_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (req_fire),
    .last_item (req.last_item),
    .acc       (acc),
    .bit_mask  (bit_mask)
  );

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1.acc     <= acc;
      s1.is_read <= (req.req_type == REQ_READ);
      s1.data    <= req.pixel_data;
    end
  end

  assign old_pixel = (wr_valid && wr_addr == s1.acc.addr) ? wr_data : ram_q;
  assign merged    = (old_pixel & ~bit_mask) | (s1.data & bit_mask);
  assign commit    = s1_adv && s1.acc.in_range && !s1.is_read;

  assign mem_we    = clearing || commit;
  assign mem_waddr = clearing ? clr_addr : s1.acc.addr;
  assign mem_wdata = clearing ? '0 : merged;

  mwpa_image_ram #(
    .DATA_W (PIXEL_W),
    .DEPTH  (STORE_SIZE),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (req_fire),
    .raddr (acc.addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (clearing) begin
      wr_valid <= 1'b0;
    end else if (commit) begin
      wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      wr_addr <= s1.acc.addr;
      wr_data <= merged;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data   <= (s1.is_read && s1.acc.in_range) ? old_pixel : '0;
      out_column <= s1.acc.column;
      out_line   <= s1.acc.line;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_data;
  assign rsp.pixel_column = out_column;
  assign rsp.pixel_line   = out_line;

  // reset always starts a clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> clearing)
    else $error("clearing pass not started after reset");

  // no requests taken while the memory is being cleared
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("request accepted during clearing pass");

  // only in-range writes leave the read stage as memory writes
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !clearing) |-> (s1_valid && s1.acc.in_range && !s1.is_read))
    else $error("memory write without an in-range write word");

  // a word held in the read stage keeps its address
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1.acc.addr)))
    else $error("read stage word lost or changed while stalled");

endmodule

`default_nettype wire

[design/mwpa_image_ram.sv]
// Generic single-write, single-read synchronous RAM, read data registered,
// read-first on a same-address collision. No dependencies.
`default_nettype none

module mwpa_image_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/mwpa_cursor.sv]
// Configuration registers and window cursor: produces the address, column and
// line of the current word and steps row-major. Depends on mwpa_pkg, mwpa_ifs.
`default_nettype none

module mwpa_cursor import mwpa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  mwpa_cfg_if.sink        cfg,
  input  wire logic       advance,
  input  wire logic       last_item,
  output access_t         acc,
  output logic [PIXEL_W-1:0] bit_mask
);

  logic [COORD_W-1:0]     window_left;
  logic [COORD_W-1:0]     window_top;
  logic [COORD_W-1:0]     window_right;
  logic [COORD_W-1:0]     window_bottom;
  logic [PLANE_SEL_W-1:0] plane_select;
  logic [COORD_W-1:0]     cursor_column;
  logic [COORD_W-1:0]     cursor_line;
  logic [COORD_W-1:0]     cursor_column_next;
  logic [COORD_W-1:0]     cursor_line_next;

  logic [COORD_W:0] columns;
  logic [COORD_W:0] lines;
  logic [COORD_W:0] col_inc;
  logic [COORD_W:0] line_inc;
  logic             cfg_fire;
  logic             window_write;
  logic [31:0]      addr_wide;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  always_comb begin
    window_write = 1'b0;
    if (cfg_fire) begin
      unique case (cfg.index) inside
        REG_WINDOW_LEFT, REG_WINDOW_TOP,
        REG_WINDOW_RIGHT, REG_WINDOW_BOTTOM: window_write = 1'b1;
        default:                             window_write = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left   <= '0;
      window_top    <= '0;
      window_right  <= '1;
      window_bottom <= '1;
      plane_select  <= '0;
      bit_mask      <= '1;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_WINDOW_LEFT:   window_left   <= cfg.data;
        REG_WINDOW_TOP:    window_top    <= cfg.data;
        REG_WINDOW_RIGHT:  window_right  <= cfg.data;
        REG_WINDOW_BOTTOM: window_bottom <= cfg.data;
        REG_PLANE_SELECT:  plane_select  <= cfg.data[PLANE_SEL_W-1:0];
        REG_BIT_MASK:      bit_mask      <= cfg.data;
        default: ;
      endcase
    end
  end

  // inverted window collapses to one column / line
  assign columns  = (window_right < window_left) ? (COORD_W+1)'(1)
                  : {1'b0, window_right} - {1'b0, window_left} + (COORD_W+1)'(1);
  assign lines    = (window_bottom < window_top) ? (COORD_W+1)'(1)
                  : {1'b0, window_bottom} - {1'b0, window_top} + (COORD_W+1)'(1);
  assign col_inc  = {1'b0, cursor_column} + (COORD_W+1)'(1);
  assign line_inc = {1'b0, cursor_line} + (COORD_W+1)'(1);

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_line_next   = cursor_line;
    if (window_write || (advance && last_item)) begin
      cursor_column_next = '0;
      cursor_line_next   = '0;
    end else if (advance) begin
      if (col_inc >= columns) begin
        cursor_column_next = '0;
        cursor_line_next   = (line_inc >= lines) ? '0 : line_inc[COORD_W-1:0];
      end else begin
        cursor_column_next = col_inc[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_line   <= '0;
    end else begin
      cursor_column <= cursor_column_next;
      cursor_line   <= cursor_line_next;
    end
  end

  // cursor stays inside the window, so these sums never carry out
  assign acc.column = window_left + cursor_column;
  assign acc.line   = window_top + cursor_line;

  assign addr_wide = (32'(plane_select) * 32'(IMAGE_HEIGHT) + 32'(acc.line))
                     * 32'(IMAGE_WIDTH) + 32'(acc.column);
  assign acc.addr  = addr_wide[ADDR_W-1:0];

  assign acc.in_range = (32'(acc.column) < 32'(IMAGE_WIDTH))
                     && (32'(acc.line) < 32'(IMAGE_HEIGHT))
                     && (32'(plane_select) < 32'(PLANE_COUNT));

endmodule

`default_nettype wire
